// ===== sv/pnpe_pkg.sv =====
// Shared types for the point-near-polygon-edge test: controller commands and datapath status.
package pnpe_pkg;

    typedef struct packed {
        logic load;       // take the input word
        logic issue;      // start one edge test
        logic sel_close;  // edge is current vertex to first vertex
        logic advance;    // previous vertex <= current vertex
        logic emit;       // load result register, end polygon
    } t_cmd;

    typedef struct packed {
        logic new_poly;   // current word opened a polygon
        logic last;       // current word is the final vertex
        logic busy;       // edge pipeline holds work
        logic out_free;   // result register can take a word
    } t_status;

endpackage

// ===== sv/pnpe_ctrl.sv =====
// Sequencer for the edge tests of one vertex and the per-polygon result.
module pnpe_ctrl import pnpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EDGE  = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EDGE;
                end
            end
            ST_EDGE: begin
                o_cmd.issue = !i_status.new_poly;
                n_state     = ST_CLOSE;
            end
            ST_CLOSE: begin
                o_cmd.issue     = i_status.last;
                o_cmd.sel_close = 1'b1;
                o_cmd.advance   = 1'b1;
                n_state         = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = i_status.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// ===== sv/pnpe_dp.sv =====
// Vertex registers, pipelined point-to-segment distance unit and result register.
module pnpe_dp import pnpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_valid,
    input  logic        [15:0] i_cfg_line_width,
    input  logic signed [15:0] i_query_x,
    input  logic signed [15:0] i_query_y,
    input  logic signed [15:0] i_vertex_x,
    input  logic signed [15:0] i_vertex_y,
    input  logic               i_last_vertex,
    input  logic               i_stall,
    output t_status            o_status,
    output logic               o_valid,
    output logic               o_near_edge
);

    logic        [15:0] r_line_width;
    logic signed [15:0] r_cur_x, r_cur_y, r_first_x, r_first_y;
    logic signed [15:0] r_prev_x, r_prev_y, r_pt_x, r_pt_y;
    logic               r_last, r_new, r_await, r_hit;
    logic               r_out_valid, r_out_hit;

    // stage 0: differences
    logic signed [15:0] s_ax, s_ay, s_bx, s_by;
    logic               r_v0;
    logic signed [16:0] r_abx, r_aby, r_apx, r_apy, r_bpx, r_bpy;
    logic        [15:0] r_w;
    // stage 1: products
    logic               r_v1;
    logic signed [33:0] r_pe1, r_pe2, r_pf1, r_pf2, r_pa1, r_pa2, r_pb1, r_pb2, r_pc1, r_pc2;
    logic        [31:0] r_w2a;
    // stage 2: sums and branch
    logic signed [34:0] s_e, s_f, s_a2, s_b2, s_cr, s_cr_abs;
    logic        [35:0] s_a4, s_b4;
    logic               r_v2, r_sel_a2, r_sel_b2, r_near_a2, r_near_b2;
    logic        [32:0] r_cr_abs, r_f;
    logic        [31:0] r_w2b;
    // stage 3: wide products
    logic               r_v3, r_sel_a3, r_sel_b3, r_near_a3, r_near_b3;
    logic        [65:0] r_lhs;
    logic        [64:0] r_rhs;
    logic               s_mid, s_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= '0;
        end else if (i_cfg_valid) begin
            r_line_width <= i_cfg_line_width;
        end
    end

    // vertex and polygon registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b1;
            r_hit   <= 1'b0;
            r_new   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_new <= r_await;
                if (r_await) begin
                    r_await <= 1'b0;
                    r_hit   <= 1'b0;
                end
            end else if (i_cmd.emit) begin
                r_await <= 1'b1;
                r_hit   <= 1'b0;
            end else if (r_v3 && s_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x <= i_vertex_x;
            r_cur_y <= i_vertex_y;
            r_last  <= i_last_vertex;
            if (r_await) begin
                r_pt_x    <= i_query_x;
                r_pt_y    <= i_query_y;
                r_first_x <= i_vertex_x;
                r_first_y <= i_vertex_y;
                r_prev_x  <= i_vertex_x;
                r_prev_y  <= i_vertex_y;
            end
        end else if (i_cmd.advance) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
    end

    // edge pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign s_ax = i_cmd.sel_close ? r_cur_x   : r_prev_x;
    assign s_ay = i_cmd.sel_close ? r_cur_y   : r_prev_y;
    assign s_bx = i_cmd.sel_close ? r_first_x : r_cur_x;
    assign s_by = i_cmd.sel_close ? r_first_y : r_cur_y;

    always_ff @(posedge i_clk) begin
        r_abx <= 17'(s_bx) - 17'(s_ax);
        r_aby <= 17'(s_by) - 17'(s_ay);
        r_apx <= 17'(r_pt_x) - 17'(s_ax);
        r_apy <= 17'(r_pt_y) - 17'(s_ay);
        r_bpx <= 17'(r_pt_x) - 17'(s_bx);
        r_bpy <= 17'(r_pt_y) - 17'(s_by);
        r_w   <= r_line_width;
    end

    always_ff @(posedge i_clk) begin
        r_pe1 <= r_apx * r_abx;
        r_pe2 <= r_apy * r_aby;
        r_pf1 <= r_abx * r_abx;
        r_pf2 <= r_aby * r_aby;
        r_pa1 <= r_apx * r_apx;
        r_pa2 <= r_apy * r_apy;
        r_pb1 <= r_bpx * r_bpx;
        r_pb2 <= r_bpy * r_bpy;
        r_pc1 <= r_apx * r_aby;
        r_pc2 <= r_apy * r_abx;
        r_w2a <= 32'(r_w) * 32'(r_w);
    end

    assign s_e      = 35'(r_pe1) + 35'(r_pe2);
    assign s_f      = 35'(r_pf1) + 35'(r_pf2);
    assign s_a2     = 35'(r_pa1) + 35'(r_pa2);
    assign s_b2     = 35'(r_pb1) + 35'(r_pb2);
    assign s_cr     = 35'(r_pc1) - 35'(r_pc2);
    assign s_cr_abs = s_cr[34] ? -s_cr : s_cr;
    assign s_a4     = {s_a2[33:0], 2'b00};
    assign s_b4     = {s_b2[33:0], 2'b00};

    always_ff @(posedge i_clk) begin
        r_sel_a2  <= (s_e <= 35'sd0);
        r_sel_b2  <= (s_e >= s_f);
        r_near_a2 <= (s_a4 <= 36'(r_w2a));
        r_near_b2 <= (s_b4 <= 36'(r_w2a));
        r_cr_abs  <= s_cr_abs[32:0];
        r_f       <= s_f[32:0];
        r_w2b     <= r_w2a;
    end

    always_ff @(posedge i_clk) begin
        r_lhs     <= 66'(r_cr_abs) * 66'(r_cr_abs);
        r_rhs     <= 65'(r_w2b) * 65'(r_f);
        r_sel_a3  <= r_sel_a2;
        r_sel_b3  <= r_sel_b2;
        r_near_a3 <= r_near_a2;
        r_near_b3 <= r_near_b2;
    end

    assign s_mid = ({r_lhs, 2'b00} <= {3'b000, r_rhs});
    assign s_hit = r_sel_a3 ? r_near_a3 : (r_sel_b3 ? r_near_b3 : s_mid);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_hit <= r_hit;
        end
    end

    assign o_status.new_poly = r_new;
    assign o_status.last     = r_last;
    assign o_status.busy     = r_v0 | r_v1 | r_v2 | r_v3;
    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_near_edge       = r_out_hit;

endmodule

// ===== sv/point_near_polygon_edge_test.sv =====
// Top level of the point-near-polygon-edge test: controller, datapath and checks.
// Vertices of a closed polygon stream in one word each; the query point is taken from the
// word of the first vertex. Each later vertex tests the edge from the previous vertex, and
// the final vertex also tests the closing edge back to the first one, through one shared
// distance pipeline (differences, products, sums, wide products, compare) that drains
// before the next word is taken; after a final vertex the block also waits until the
// result register is free of a stalled consumer. One near_edge word per polygon.
// line_width is to be written only while idle; the block does not enforce it. Its ready is always high.
module point_near_polygon_edge_test import pnpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [15:0] i_cfg_line_width,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_query_x,
    input  logic signed [15:0] i_query_y,
    input  logic signed [15:0] i_vertex_x,
    input  logic signed [15:0] i_vertex_y,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_near_edge
);

    t_cmd    s_cmd;
    t_status s_status;

    assign o_cfg_ready = 1'b1;

    pnpe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (s_status),
        .o_stall  (o_stall),
        .o_cmd    (s_cmd)
    );

    pnpe_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_line_width (i_cfg_line_width),
        .i_query_x        (i_query_x),
        .i_query_y        (i_query_y),
        .i_vertex_x       (i_vertex_x),
        .i_vertex_y       (i_vertex_y),
        .i_last_vertex    (i_last_vertex),
        .i_stall          (i_stall),
        .o_status         (s_status),
        .o_valid          (o_valid),
        .o_near_edge      (o_near_edge)
    );

`ifndef SYNTHESIS
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while the block stays open");

    a_issue_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.issue |-> o_stall)
        else $error("edge test started while taking input");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |-> (!s_status.busy && s_status.last))
        else $error("result emitted before edge pipeline drained");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s_cmd.emit))
        else $error("result word without emit");
`endif

endmodule
